FILE: hdl/srrq_pkg.sv
package srrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] proc_id;
        logic [15:0] remaining;
        logic [15:0] arrival;
        logic [7:0]  label;
        logic [15:0] exec_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        empty_res;
        logic [4:0]  count;
        logic [15:0] head_id;
        logic [15:0] head_remaining;
        logic [15:0] head_arrival;
        logic [7:0]  head_label;
        logic [15:0] head_exec;
    } out_item_t;

    // sort key is {remaining, proc_id}, compared as one unsigned word
    typedef struct packed {
        logic [15:0] remaining;
        logic [15:0] proc_id;
        logic [15:0] arrival;
        logic [7:0]  label;
        logic [15:0] exec_time;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN_RD,
        SEQ_SCAN_CMP,
        SEQ_HEAD_RD,
        SEQ_DONE
    } seq_state_t;

endpackage

FILE: hdl/shortest_remaining_ready_queue_unit.sv
// Channel   Handshake            Payload
// input     in_valid/in_ready    in_data  (in_item_t)
// output    out_valid/out_ready  out_data (out_item_t)
//
// Entries live in a ring buffer; one comparator and one memory walk a push
// back from the tail, one entry moved per SCAN_RD/SCAN_CMP pass. Pop and full-push
// go IDLE, HEAD_RD, DONE; a push loops SCAN_RD/SCAN_CMP over the entries above
// the new key, then writes it and goes on to HEAD_RD and DONE.
// rst_n (async, active low) empties the queue; no clearing pass is needed.
// A result waits in the output register; a new transaction is taken meanwhile
// but its result is held back until that register frees up.
module shortest_remaining_ready_queue_unit
    import srrq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    logic      result_ready;
    logic      result_valid;
    out_item_t result;
    mem_req_t  mem_req;
    entry_t    mem_rd_data;

    srrq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data)
    );

    srrq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign result_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid && result_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_valid && result_ready)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/srrq_mem.sv
module srrq_mem
    import srrq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/srrq_ctrl.sv
module srrq_ctrl
    import srrq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    input  logic      result_ready,
    output logic      result_valid,
    output out_item_t result,
    output mem_req_t  mem_req,
    input  entry_t    mem_rd_data
);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    entry_t           new_reg, new_next;
    status_t          status_reg, status_next;

    logic             accept;
    logic             queue_empty;
    logic             queue_full;
    logic             entry_greater;

    // logical position -> physical slot of the ring
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] lpos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lpos};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign accept        = in_valid && in_ready;
    assign queue_empty   = (count_reg == '0);
    assign queue_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    // the one comparator: held entry strictly above the new key moves up a slot
    assign entry_greater = {mem_rd_data.remaining, mem_rd_data.proc_id} >
                           {new_reg.remaining, new_reg.proc_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_PUSH && !queue_full)
                        state_next = SEQ_SCAN_RD;
                    else
                        state_next = SEQ_HEAD_RD;
                end
            end
            SEQ_SCAN_RD:
            begin
                if (pos_reg == '0)
                    state_next = SEQ_HEAD_RD;
                else
                    state_next = SEQ_SCAN_CMP;
            end
            SEQ_SCAN_CMP:
            begin
                if (entry_greater)
                    state_next = SEQ_SCAN_RD;
                else
                    state_next = SEQ_HEAD_RD;
            end
            SEQ_HEAD_RD:
            begin
                state_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (result_ready)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        result_valid  = 1'b0;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        status_next   = status_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = phys_addr(head_reg, pos_reg);
        mem_req.wdata = new_reg;
        mem_req.re    = 1'b0;
        mem_req.raddr = head_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = STATUS_OK;
                    new_next    = '{remaining: in_data.remaining,
                                    proc_id:   in_data.proc_id,
                                    arrival:   in_data.arrival,
                                    label:     in_data.label,
                                    exec_time: in_data.exec_time};
                    if (in_data.mode == MODE_POP)
                    begin
                        if (queue_empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            head_next  = phys_addr(head_reg, IDX_W'(1));
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (queue_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        pos_next = count_reg[IDX_W-1:0];
                    end
                end
            end
            SEQ_SCAN_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.we = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = phys_addr(head_reg, pos_reg - IDX_W'(1));
                end
            end
            SEQ_SCAN_CMP:
            begin
                mem_req.we = 1'b1;
                if (entry_greater)
                begin
                    mem_req.wdata = mem_rd_data;
                    pos_next      = pos_reg - IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            SEQ_HEAD_RD:
            begin
                mem_req.re = 1'b1;
            end
            SEQ_DONE:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.status    = status_reg;
        result.empty_res = queue_empty;
        result.count     = 5'(count_reg);
        if (queue_empty)
        begin
            result.head_id        = '0;
            result.head_remaining = '0;
            result.head_arrival   = '0;
            result.head_label     = '0;
            result.head_exec      = '0;
        end
        else
        begin
            result.head_id        = mem_rd_data.proc_id;
            result.head_remaining = mem_rd_data.remaining;
            result.head_arrival   = mem_rd_data.arrival;
            result.head_label     = mem_rd_data.label;
            result.head_exec      = mem_rd_data.exec_time;
        end
    end

endmodule
